### sv/mp3_frame_header_decoder_top_defines.svh
// Assertion macros for the MPEG audio frame header decoder.
// Expects clk and rst in the scope of each use; no other dependencies.
`ifndef MP3_FRAME_HEADER_DECODER_TOP_DEFINES_SVH
`define MP3_FRAME_HEADER_DECODER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define MFHD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define MFHD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define MFHD_ASSERT_IMP(lbl, ante, cons)
`define MFHD_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

### sv/mp3fhd_pkg.sv
// Shared types, constants and header decode for the MPEG audio frame header decoder.
// No dependencies.
package mp3fhd_pkg;

  localparam int NUM_W  = 26;
  localparam int DEN_W  = 17;
  localparam int QUOT_W = 11;

  localparam logic [31:0] SYNC_MASK = 32'hffe0_0000;
  localparam logic [31:0] RSVD_MASK = 32'h0000_fc00;
  localparam logic [NUM_W-1:0] KBPS_SCALE = 26'd144000;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_SYNC    = 3'd1,
    ST_LAYER   = 3'd2,
    ST_RATE    = 3'd3,
    ST_FREE    = 3'd4,
    ST_BITRATE = 3'd5
  } status_t;

  localparam logic [1:0] LAYER_III  = 2'b01;
  localparam logic [1:0] RATE_RSVD  = 2'b11;
  localparam logic [1:0] MODE_MONO  = 2'b11;
  localparam logic [3:0] BIX_FREE   = 4'd0;

  localparam logic [8:0] KBPS_V1 [16] = '{
    9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
    9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0
  };
  localparam logic [8:0] KBPS_V2 [16] = '{
    9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
    9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0
  };
  localparam logic [15:0] RATE_HZ [9] = '{
    16'd44100, 16'd48000, 16'd32000, 16'd22050, 16'd24000,
    16'd16000, 16'd11025, 16'd12000, 16'd8000
  };

  typedef struct packed {
    status_t     status;
    logic [8:0]  kbps;
    logic [15:0] hz;
    logic [1:0]  chans;
    logic        pad;
  } side_t;

  typedef struct packed {
    side_t side;
    logic  lsf;
  } dec_t;

  function automatic dec_t decode(input logic [31:0] h);
    dec_t       d;
    logic [1:0] rix;
    logic [3:0] bix;
    logic [3:0] sfi;
    logic       lsf;
    logic [8:0] kbps;
    d   = '0;
    rix = h[11:10];
    bix = h[15:12];
    if (h[20]) begin
      lsf = ~h[19];
      sfi = lsf ? (4'(rix) + 4'd3) : 4'(rix);
    end else begin
      lsf = 1'b1;
      sfi = 4'(rix) + 4'd6;
    end
    kbps = lsf ? KBPS_V2[bix] : KBPS_V1[bix];
    d.lsf = lsf;
    if ((h & SYNC_MASK) != SYNC_MASK || (h & RSVD_MASK) == RSVD_MASK) begin
      d.side.status = ST_SYNC;
    end else if (h[18:17] != LAYER_III) begin
      d.side.status = ST_LAYER;
    end else if (rix == RATE_RSVD) begin
      d.side.status = ST_RATE;
    end else if (bix == BIX_FREE) begin
      d.side.status = ST_FREE;
    end else if (kbps == 9'd0) begin
      d.side.status = ST_BITRATE;
    end else begin
      d.side.status = ST_OK;
      d.side.kbps   = kbps;
      d.side.hz     = RATE_HZ[sfi];
      d.side.chans  = (h[7:6] == MODE_MONO) ? 2'd1 : 2'd2;
      d.side.pad    = h[9];
    end
    return d;
  endfunction

endpackage

### sv/mp3fhd_div_pipe.sv
// Restoring divider pipeline, one quotient bit per register stage, with side data.
// Depends on mp3fhd_pkg.
module mp3fhd_div_pipe (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [mp3fhd_pkg::NUM_W-1:0]     num,
  input  logic [mp3fhd_pkg::DEN_W-1:0]     den,
  input  mp3fhd_pkg::side_t                side_in,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [mp3fhd_pkg::QUOT_W-1:0]    quot,
  output mp3fhd_pkg::side_t                side_out
);
  import mp3fhd_pkg::*;

  localparam int CMP_W = NUM_W + 2;

  logic [NUM_W-1:0]  rem  [QUOT_W];
  logic [DEN_W-1:0]  dreg [QUOT_W];
  logic [QUOT_W-1:0] qreg [QUOT_W];
  side_t             sreg [QUOT_W];
  logic [QUOT_W-1:0] v;
  logic [QUOT_W:0]   en;

  assign en[QUOT_W] = out_ready;
  assign in_ready   = en[0];

  for (genvar k = 0; k < QUOT_W; k++) begin : g_stage
    localparam int SH = QUOT_W - 1 - k;
    logic [NUM_W-1:0]  r_in;
    logic [DEN_W-1:0]  d_in;
    logic [QUOT_W-1:0] q_in;
    side_t             s_in;
    logic              v_in;
    logic [CMP_W-1:0]  dsh;
    logic              fit;

    if (k == 0) begin : g_first
      assign r_in = num;
      assign d_in = den;
      assign q_in = '0;
      assign s_in = side_in;
      assign v_in = in_valid;
    end else begin : g_rest
      assign r_in = rem[k-1];
      assign d_in = dreg[k-1];
      assign q_in = qreg[k-1];
      assign s_in = sreg[k-1];
      assign v_in = v[k-1];
    end

    assign en[k] = ~v[k] | en[k+1];
    assign dsh   = CMP_W'(d_in) << SH;
    assign fit   = {2'b00, r_in} >= dsh;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en[k]) begin
        v[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        rem[k]  <= fit ? (r_in - dsh[NUM_W-1:0]) : r_in;
        dreg[k] <= d_in;
        qreg[k] <= q_in | (fit ? (QUOT_W'(1) << SH) : '0);
        sreg[k] <= s_in;
      end
    end
  end

  assign out_valid = v[QUOT_W-1];
  assign quot      = qreg[QUOT_W-1];
  assign side_out  = sreg[QUOT_W-1];

endmodule

### sv/mp3_frame_header_decoder_top.sv
// MPEG audio Layer III frame header decoder. Takes one 32-bit header word per
// transfer and returns one result per header: status, frame length in bytes,
// bitrate, sample rate and channel count; on any error all fields but status
// are zero. Fully pipelined: one header per cycle when there is no back pressure,
// through these register stages: decode and table lookup, bitrate scaling
// multiply, eleven restoring-divider stages that each resolve one quotient bit,
// output register. Each stage holds only under back pressure, so empty stages fill up.
// Depends on mp3fhd_pkg, mp3fhd_div_pipe and mp3_frame_header_decoder_top_defines.svh.
`include "mp3_frame_header_decoder_top_defines.svh"

module mp3_frame_header_decoder_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] header_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [10:0] frame_bytes,
  output logic [8:0]  bitrate_kbps,
  output logic [15:0] sample_rate_hz,
  output logic [1:0]  channel_count
);
  import mp3fhd_pkg::*;

  // decode stage
  logic  a_v;
  dec_t  a_dec;
  logic  a_en;
  // scaling stage
  logic              b_v;
  logic [NUM_W-1:0]  b_num;
  logic [DEN_W-1:0]  b_den;
  side_t             b_side;
  logic              b_en;
  // divider
  logic              div_in_ready;
  logic              div_v;
  logic [QUOT_W-1:0] div_q;
  side_t             div_side;
  // output stage
  logic              o_v;
  logic              o_en;
  logic              fields_zero;
  logic              fields_set;

  assign o_en     = ~o_v | out_ready;
  assign b_en     = ~b_v | div_in_ready;
  assign a_en     = ~a_v | b_en;
  assign in_ready = a_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
      o_v <= 1'b0;
    end else begin
      if (a_en) begin
        a_v <= in_valid;
      end
      if (b_en) begin
        b_v <= a_v;
      end
      if (o_en) begin
        o_v <= div_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_en) begin
      a_dec <= decode(header_word);
    end
    if (b_en) begin
      b_num  <= NUM_W'(a_dec.side.kbps) * KBPS_SCALE;
      b_den  <= a_dec.lsf ? {a_dec.side.hz, 1'b0} : {1'b0, a_dec.side.hz};
      b_side <= a_dec.side;
    end
    if (o_en) begin
      status         <= div_side.status;
      frame_bytes    <= (div_side.status == ST_OK) ? (div_q + QUOT_W'(div_side.pad)) : '0;
      bitrate_kbps   <= div_side.kbps;
      sample_rate_hz <= div_side.hz;
      channel_count  <= div_side.chans;
    end
  end

  mp3fhd_div_pipe u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (b_v),
    .in_ready  (div_in_ready),
    .num       (b_num),
    .den       (b_den),
    .side_in   (b_side),
    .out_valid (div_v),
    .out_ready (o_en),
    .quot      (div_q),
    .side_out  (div_side)
  );

  assign out_valid = o_v;

  assign fields_zero = frame_bytes == 11'd0 && bitrate_kbps == 9'd0 &&
                       sample_rate_hz == 16'd0 && channel_count == 2'd0;
  assign fields_set  = frame_bytes != 11'd0 && bitrate_kbps != 9'd0 &&
                       sample_rate_hz != 16'd0 && channel_count != 2'd0;

  `MFHD_ASSERT_IMP(a_err_zero, out_valid && status != ST_OK, fields_zero)
  `MFHD_ASSERT_IMP(a_ok_fields, out_valid && status == ST_OK, fields_set)
  `MFHD_ASSERT_NXT(a_enter, in_valid && in_ready, a_v)

endmodule

### verif/mp3_frame_header_decoder_tb.sv
// Testbench for mp3_frame_header_decoder_top: directed and random header words,
// random idles on both sides, results checked in order against a local decoder.
// Depends on mp3fhd_pkg (status codes) and the RTL of the block.
module tb;
  import mp3fhd_pkg::*;

  localparam logic [1:0] VER_MPEG25 = 2'b00;
  localparam logic [1:0] VER_RSVD   = 2'b01;
  localparam logic [1:0] VER_MPEG2  = 2'b10;
  localparam logic [1:0] VER_MPEG1  = 2'b11;
  localparam logic [1:0] LYR_RSVD   = 2'b00;
  localparam logic [1:0] LYR_3      = 2'b01;
  localparam logic [1:0] LYR_2      = 2'b10;
  localparam logic [1:0] LYR_1      = 2'b11;
  localparam logic [1:0] RIX_RSVD   = 2'b11;
  localparam logic [3:0] BIX_FREEFMT = 4'd0;
  localparam logic [3:0] BIX_BAD    = 4'd15;
  localparam logic [1:0] CH_MONO    = 2'b11;
  localparam logic [1:0] CH_STEREO  = 2'b00;
  localparam int N_RANDOM    = 1930;
  localparam int HOLD_AT     = 400;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    status_t     status;
    logic [10:0] frame_bytes;
    logic [8:0]  bitrate_kbps;
    logic [15:0] sample_rate_hz;
    logic [1:0]  channel_count;
  } hdr_result_t;

  class frame_scoreboard;
    hdr_result_t pending[$];
    int errors;
    int n_checked;
    int n_ok;

    function hdr_result_t decode_header(logic [31:0] h);
      hdr_result_t r;
      logic [1:0]  rix;
      logic [3:0]  bix;
      bit          lsf;
      int          sfi;
      int          kbps;
      int          hz;
      int          v1_kbps[16] = '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192,
                                   224, 256, 320, 0};
      int          v2_kbps[16] = '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112,
                                   128, 144, 160, 0};
      int          rates[9] = '{44100, 48000, 32000, 22050, 24000, 16000, 11025,
                                12000, 8000};
      r = '0;
      r.status = ST_OK;
      rix = h[11:10];
      bix = h[15:12];
      if (h[31:21] != 11'h7ff || h[15:10] == 6'h3f) begin
        r.status = ST_SYNC;
      end else if (h[18:17] != LYR_3) begin
        r.status = ST_LAYER;
      end else if (rix == RIX_RSVD) begin
        r.status = ST_RATE;
      end else begin
        // bit 20 clear means MPEG-2.5 regardless of bit 19
        if (h[20]) begin
          lsf = !h[19];
          sfi = int'(rix) + (lsf ? 3 : 0);
        end else begin
          lsf = 1'b1;
          sfi = 6 + int'(rix);
        end
        kbps = lsf ? v2_kbps[bix] : v1_kbps[bix];
        if (bix == BIX_FREEFMT) begin
          r.status = ST_FREE;
        end else if (kbps == 0) begin
          r.status = ST_BITRATE;
        end else begin
          hz = rates[sfi];
          r.frame_bytes    = 11'((kbps * 144000) / (hz << lsf) + int'(h[9]));
          r.bitrate_kbps   = 9'(kbps);
          r.sample_rate_hz = 16'(hz);
          r.channel_count  = (h[7:6] == CH_MONO) ? 2'd1 : 2'd2;
        end
      end
      return r;
    endfunction

    function void note_header(logic [31:0] h);
      pending.push_back(decode_header(h));
    endfunction

    function void report(string field, int exp_v, int act_v);
      if (exp_v != act_v) begin
        $error("%s: expected %0d, actual %0d", field, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(hdr_result_t got);
      hdr_result_t exp_r;
      if (pending.size() == 0) begin
        $error("unexpected result transfer: status %0d, frame_bytes %0d",
               got.status, got.frame_bytes);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      n_checked++;
      if (exp_r.status == ST_OK) n_ok++;
      report("status", exp_r.status, got.status);
      report("frame_bytes", exp_r.frame_bytes, got.frame_bytes);
      report("bitrate_kbps", exp_r.bitrate_kbps, got.bitrate_kbps);
      report("sample_rate_hz", exp_r.sample_rate_hz, got.sample_rate_hz);
      report("channel_count", exp_r.channel_count, got.channel_count);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] header_word;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  status;
  logic [10:0] frame_bytes;
  logic [8:0]  bitrate_kbps;
  logic [15:0] sample_rate_hz;
  logic [1:0]  channel_count;

  frame_scoreboard sb;
  int send_max;
  int recv_max;
  int n_sent;

  mp3_frame_header_decoder_top dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .header_word    (header_word),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .frame_bytes    (frame_bytes),
    .bitrate_kbps   (bitrate_kbps),
    .sample_rate_hz (sample_rate_hz),
    .channel_count  (channel_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // header with sync set and the named fields placed; all other bits random
  function automatic logic [31:0] make_header(logic [1:0] ver, logic [1:0] layer,
                                              logic [3:0] bix, logic [1:0] rix,
                                              logic pad, logic [1:0] mode);
    logic [31:0] h;
    h = $urandom;
    h[31:21] = 11'h7ff;
    h[20:19] = ver;
    h[18:17] = layer;
    h[15:12] = bix;
    h[11:10] = rix;
    h[9]     = pad;
    h[7:6]   = mode;
    return h;
  endfunction

  task automatic send_header(logic [31:0] h);
    int gap;
    if (n_sent % 40 == 0)
      send_max = ($urandom_range(0, 2) == 0) ? 0 : 8;
    gap = $urandom_range(0, send_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    header_word <= h;
    do @(posedge clk); while (!in_ready);
    sb.note_header(h);
    n_sent++;
  endtask

  task automatic take_results();
    int stall;
    int taken;
    hdr_result_t got;
    taken = 0;
    forever begin
      if (taken % 40 == 0)
        recv_max = ($urandom_range(0, 2) == 0) ? 0 : 8;
      // one long hold-off so the pipeline fills and stalls the input side
      stall = (taken == HOLD_AT) ? HOLD_CYCLES : $urandom_range(0, recv_max);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got.status         = status_t'(status);
      got.frame_bytes    = frame_bytes;
      got.bitrate_kbps   = bitrate_kbps;
      got.sample_rate_hz = sample_rate_hz;
      got.channel_count  = channel_count;
      sb.check_result(got);
      taken++;
    end
  endtask

  task automatic run_directed();
    send_header(32'h0000_0000);
    send_header(32'hffff_ffff);
    send_header(32'hffdf_ffff);
    send_header(32'hfffb_9064);
    send_header(make_header(VER_MPEG1, LYR_RSVD, 4'd9, 2'd0, 1'b0, CH_STEREO));
    send_header(make_header(VER_MPEG1, LYR_2, 4'd9, 2'd0, 1'b0, CH_STEREO));
    send_header(make_header(VER_MPEG1, LYR_1, 4'd9, 2'd0, 1'b0, CH_STEREO));
    send_header(make_header(VER_MPEG1, LYR_3, 4'd9, RIX_RSVD, 1'b0, CH_STEREO));
    send_header(make_header(VER_MPEG2, LYR_3, 4'd5, RIX_RSVD, 1'b1, CH_MONO));
    send_header(make_header(VER_MPEG25, LYR_3, 4'd1, RIX_RSVD, 1'b0, CH_STEREO));
    send_header(make_header(VER_MPEG1, LYR_3, BIX_FREEFMT, 2'd1, 1'b0, CH_STEREO));
    send_header(make_header(VER_MPEG2, LYR_3, BIX_FREEFMT, 2'd0, 1'b1, CH_MONO));
    send_header(make_header(VER_MPEG1, LYR_3, BIX_BAD, 2'd0, 1'b0, CH_STEREO));
    send_header(make_header(VER_MPEG25, LYR_3, BIX_BAD, 2'd2, 1'b1, CH_STEREO));
    send_header(make_header(VER_MPEG1, LYR_3, BIX_BAD, RIX_RSVD, 1'b0, CH_STEREO));
    send_header(make_header(VER_MPEG1, LYR_3, 4'd14, 2'd2, 1'b1, CH_STEREO));
    send_header(make_header(VER_MPEG1, LYR_3, 4'd1, 2'd1, 1'b0, CH_MONO));
    send_header(make_header(VER_MPEG2, LYR_3, 4'd14, 2'd0, 1'b0, CH_STEREO));
    send_header(make_header(VER_MPEG2, LYR_3, 4'd8, 2'd1, 1'b1, CH_MONO));
    send_header(make_header(VER_MPEG2, LYR_3, 4'd1, 2'd2, 1'b0, CH_STEREO));
    send_header(make_header(VER_MPEG25, LYR_3, 4'd1, 2'd2, 1'b0, CH_STEREO));
    send_header(make_header(VER_MPEG25, LYR_3, 4'd14, 2'd0, 1'b1, CH_MONO));
    send_header(make_header(VER_RSVD, LYR_3, 4'd7, 2'd1, 1'b0, CH_STEREO));
    send_header(make_header(VER_RSVD, LYR_3, 4'd13, 2'd2, 1'b1, CH_MONO));
  endtask

  task automatic run_random();
    logic [31:0] h;
    int          pick;
    logic [3:0]  bix;
    for (int i = 0; i < N_RANDOM; i++) begin
      pick = $urandom_range(0, 99);
      bix  = ($urandom_range(0, 15) == 0) ? 4'($urandom) : 4'($urandom_range(1, 14));
      h = make_header(2'($urandom), LYR_3, bix, 2'($urandom_range(0, 2)),
                      1'($urandom), 2'($urandom));
      if (pick >= 90) begin
        h = $urandom;
      end else if (pick >= 80) begin
        h[31 - $urandom_range(0, 10)] = 1'b0;
      end else if (pick >= 70) begin
        h[18:17] = 2'($urandom);
        h[11:10] = 2'($urandom);
        h[15:12] = 4'($urandom);
      end
      send_header(h);
    end
  endtask

  initial begin
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    header_word <= '0;
    out_ready   <= 1'b0;
    sb       = new();
    send_max = 0;
    recv_max = 0;
    n_sent   = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    fork
      take_results();
    join_none
    run_directed();
    run_random();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Sent %0d headers; checked %0d results, %0d decoded ok, %0d rejected.",
             n_sent, sb.n_checked, sb.n_ok, sb.n_checked - sb.n_ok);
    $display("Mismatches or stray results: %0d", sb.errors);
    if (sb.errors == 0) begin
      $display("mp3_frame_header_decoder_top regression: pass");
    end else begin
      $display("mp3_frame_header_decoder_top regression: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout: run did not complete");
    $display("mp3_frame_header_decoder_top regression: fail");
    $finish;
  end

endmodule
